// ----- sv/lgvta_pkg.sv -----
// ----------------------------------------------------------------------------
// lgvta_pkg: shared types and constants of the lidar gated target approach
// Transaction payloads, configuration record, command codes and the fixed
// constants of the steering law.
// ----------------------------------------------------------------------------
package lgvta_pkg;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_LAST   = 2'd1,
		CMD_EMPTY  = 2'd2,
		CMD_FRAME  = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] sample_angle;
		logic [15:0] sample_range;
		logic        range_finite;
		logic [15:0] scan_range_min;
		logic [15:0] scan_range_max;
		logic        target_found;
		logic [11:0] target_x;
		logic [12:0] image_width;
	} in_item_t;

	typedef struct packed {
		logic               result_kind;
		logic [15:0]        front_distance;
		logic               distance_valid;
		logic               target_detected;
		logic               near_target;
		logic [10:0]        linear_speed;
		logic signed [15:0] turn_rate;
	} out_item_t;

	typedef struct packed {
		logic [15:0] sector_center;
		logic [14:0] sector_half_width;
		logic [15:0] stop_threshold;
		logic [15:0] resume_threshold;
		logic [7:0]  confirm_frames;
		logic [12:0] yaw_gain;
		logic [14:0] center_tolerance;
		logic [10:0] forward_speed;
	} cfg_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SECTOR_CENTER     = 3'd0;
	localparam logic [2:0] CFG_SECTOR_HALF_WIDTH = 3'd1;
	localparam logic [2:0] CFG_STOP_THRESHOLD    = 3'd2;
	localparam logic [2:0] CFG_RESUME_THRESHOLD  = 3'd3;
	localparam logic [2:0] CFG_CONFIRM_FRAMES    = 3'd4;
	localparam logic [2:0] CFG_YAW_GAIN          = 3'd5;
	localparam logic [2:0] CFG_CENTER_TOLERANCE  = 3'd6;
	localparam logic [2:0] CFG_FORWARD_SPEED     = 3'd7;

	localparam cfg_t CFG_RESET = '{
		sector_center:     16'd32768,
		sector_half_width: 15'd1820,
		stop_threshold:    16'd520,
		resume_threshold:  16'd550,
		confirm_frames:    8'd2,
		yaw_gain:          13'd800,
		center_tolerance:  15'd2621,
		forward_speed:     11'd250
	};

	localparam logic                RESULT_REPORT = 1'b0;
	localparam logic                RESULT_DRIVE  = 1'b1;

	localparam logic signed [15:0] SEARCH_TURN_RATE   = 16'sd600;
	localparam logic [15:0]        CENTERED_LIMIT_Q15 = 16'd11469;
	localparam logic [12:0]        MIN_TURN           = 13'd120;
	localparam logic signed [15:0] MIN_TURN_RATE      = 16'sd120;
	localparam logic [15:0]        ERR_SAT_POS        = 16'd32767;
	localparam logic [15:0]        ERR_SAT_NEG_MAG    = 16'd32768;
	localparam logic [7:0]         COUNT_MAX          = 8'd255;

	// Shared adder: wide enough for the 13 x 16 bit shift-add product.
	localparam int ALU_W = 28;

	// Iteration counts: 15 quotient bits, 13 multiplier bits.
	localparam logic [3:0] DIV_LAST_STEP = 4'd14;
	localparam logic [3:0] MUL_LAST_STEP = 4'd12;

	typedef struct packed {
		logic             carry;
		logic [ALU_W-1:0] sum;
	} alu_res_t;

	typedef struct packed {
		logic [15:0] front_range;
		logic        front_valid;
	} front_t;

endpackage

// ----- sv/lgvta_alu.sv -----
// ----------------------------------------------------------------------------
// lgvta_alu: shared add and subtract unit
// One adder used by the divider for trial subtraction and by the multiplier
// for shift-and-add accumulation. Carry out on subtraction means a >= b.
// ----------------------------------------------------------------------------
module lgvta_alu (
	input  logic [lgvta_pkg::ALU_W-1:0] a,
	input  logic [lgvta_pkg::ALU_W-1:0] b,
	input  logic                        sub,
	output lgvta_pkg::alu_res_t         res
);

	logic [lgvta_pkg::ALU_W-1:0] b_op;

	assign b_op = sub ? ~b : b;
	assign {res.carry, res.sum} = {1'b0, a} + {1'b0, b_op}
		+ {{lgvta_pkg::ALU_W{1'b0}}, sub};

endmodule

// ----- sv/lgvta_scan.sv -----
// ----------------------------------------------------------------------------
// lgvta_scan: front sector minimum tracker
// Qualifies lidar samples against the sector and range gates, keeps the
// running minimum and turns it into the front distance at the end of a scan.
// ----------------------------------------------------------------------------
module lgvta_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_en,
	input  logic                close_en,
	input  lgvta_pkg::in_item_t item,
	input  lgvta_pkg::cfg_t     cfg,
	output lgvta_pkg::front_t   front,
	output lgvta_pkg::front_t   front_next
);

	logic [15:0] min_q;
	logic        min_valid_q;
	logic [15:0] front_q;
	logic        front_valid_q;

	logic [15:0] diff;
	logic [15:0] mag;
	logic        counts;
	logic        take;
	logic [15:0] min_upd;
	logic        min_valid_upd;

	always_comb begin
		diff = item.sample_angle - cfg.sector_center;
		mag  = diff[15] ? (~diff + 16'd1) : diff;
		counts = (mag <= {1'b0, cfg.sector_half_width}) && item.range_finite
			&& (item.sample_range > item.scan_range_min)
			&& (item.sample_range < item.scan_range_max);
		take = sample_en && counts && (!min_valid_q || item.sample_range < min_q);
		min_upd       = take ? item.sample_range : min_q;
		min_valid_upd = take || min_valid_q;
		// An empty scan ignores the sample fields altogether.
		if (item.command == lgvta_pkg::CMD_LAST && min_valid_upd) begin
			front_next.front_range = min_upd;
			front_next.front_valid = 1'b1;
		end else begin
			front_next.front_range = 16'd0;
			front_next.front_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q         <= 16'hFFFF;
			min_valid_q   <= 1'b0;
			front_q       <= 16'd0;
			front_valid_q <= 1'b0;
		end else if (close_en) begin
			min_q         <= 16'hFFFF;
			min_valid_q   <= 1'b0;
			front_q       <= front_next.front_range;
			front_valid_q <= front_next.front_valid;
		end else if (take) begin
			min_q       <= min_upd;
			min_valid_q <= min_valid_upd;
		end
	end

	assign front.front_range = front_q;
	assign front.front_valid = front_valid_q;

endmodule

// ----- sv/lgvta_drive.sv -----
// ----------------------------------------------------------------------------
// lgvta_drive: camera frame steering sequencer
// Works out the Q15 centering error by restoring division, scales it by the
// yaw gain by shift-and-add, both on the shared adder, then applies the
// minimum turn, the close-frame confirmation and the stop latch.
// ----------------------------------------------------------------------------
module lgvta_drive (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  lgvta_pkg::in_item_t  frame,
	input  lgvta_pkg::cfg_t      cfg,
	input  lgvta_pkg::front_t    front,
	output logic                 busy,
	output logic                 done,
	output lgvta_pkg::out_item_t result
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_POST = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [3:0]                  step_q;
	logic [12:0]                 rem_q;
	logic [14:0]                 quot_q;
	logic [12:0]                 width_q;
	logic [15:0]                 aerr_q;
	logic                        err_neg_q;
	logic                        found_q;
	logic [lgvta_pkg::ALU_W-1:0] acc_q;
	logic                        latch_q;
	logic [7:0]                  count_q;

	logic [13:0]                 twice_x;
	logic [13:0]                 numer;
	logic [12:0]                 numer_mag;
	logic [lgvta_pkg::ALU_W-1:0] alu_a;
	logic [lgvta_pkg::ALU_W-1:0] alu_b;
	logic                        alu_sub;
	lgvta_pkg::alu_res_t         alu_res;
	logic [14:0]                 quot_next;
	logic [3:0]                  gain_idx;

	logic [12:0]                 turn_mag;
	logic signed [15:0]          turn_prop;
	logic signed [15:0]          turn_cmd;
	logic                        close;
	logic [7:0]                  count_next;
	logic                        latch_next;
	logic                        near;

	always_comb begin
		twice_x   = {1'b0, frame.target_x, 1'b0};
		numer     = {1'b0, frame.image_width} - twice_x;
		numer_mag = numer[13] ? 13'(~numer + 14'd1) : numer[12:0];
	end

	always_comb begin
		gain_idx = MUL_IDX(step_q);
		if (state_q == ST_DIV) begin
			alu_a   = {{(lgvta_pkg::ALU_W-14){1'b0}}, rem_q, 1'b0};
			alu_b   = {{(lgvta_pkg::ALU_W-13){1'b0}}, width_q};
			alu_sub = 1'b1;
		end else begin
			alu_a   = {acc_q[lgvta_pkg::ALU_W-2:0], 1'b0};
			alu_b   = cfg.yaw_gain[gain_idx]
				? {{(lgvta_pkg::ALU_W-16){1'b0}}, aerr_q} : '0;
			alu_sub = 1'b0;
		end
		quot_next = {quot_q[13:0], alu_res.carry};
	end

	function automatic logic [3:0] MUL_IDX(input logic [3:0] step);
		MUL_IDX = lgvta_pkg::MUL_LAST_STEP - step;
	endfunction

	lgvta_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	// Final steering law, evaluated in the closing cycle.
	always_comb begin
		turn_mag  = acc_q[lgvta_pkg::ALU_W-1:15];
		turn_prop = err_neg_q ? $signed({3'b000, turn_mag})
			: -$signed({3'b000, turn_mag});
		turn_cmd = turn_prop;
		if (turn_mag < lgvta_pkg::MIN_TURN && aerr_q > {1'b0, cfg.center_tolerance}) begin
			turn_cmd = (err_neg_q && turn_mag != 13'd0)
				? lgvta_pkg::MIN_TURN_RATE : -lgvta_pkg::MIN_TURN_RATE;
		end

		close = front.front_valid && front.front_range <= cfg.stop_threshold;
		if (close) begin
			count_next = (count_q == lgvta_pkg::COUNT_MAX) ? count_q : count_q + 8'd1;
		end else begin
			count_next = 8'd0;
		end
		latch_next = latch_q;
		near       = 1'b0;
		if (count_next >= cfg.confirm_frames) begin
			latch_next = 1'b1;
			near       = 1'b1;
		end else if (latch_q) begin
			if (front.front_valid && front.front_range > cfg.resume_threshold) begin
				latch_next = 1'b0;
				count_next = 8'd0;
			end else begin
				near = 1'b1;
			end
		end

		result.result_kind     = lgvta_pkg::RESULT_DRIVE;
		result.front_distance  = front.front_range;
		result.distance_valid  = front.front_valid;
		result.target_detected = found_q;
		if (!found_q) begin
			result.near_target  = 1'b0;
			result.linear_speed = 11'd0;
			result.turn_rate    = lgvta_pkg::SEARCH_TURN_RATE;
		end else if (near) begin
			result.near_target  = 1'b1;
			result.linear_speed = 11'd0;
			result.turn_rate    = 16'sd0;
		end else begin
			result.near_target  = 1'b0;
			result.linear_speed = (aerr_q < lgvta_pkg::CENTERED_LIMIT_Q15)
				? cfg.forward_speed : 11'd0;
			result.turn_rate    = turn_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= 4'd0;
			latch_q <= 1'b0;
			count_q <= 8'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						step_q <= 4'd0;
						if (!frame.target_found || frame.image_width == 13'd0) begin
							state_q <= ST_POST;
						end else if (numer_mag >= frame.image_width) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == lgvta_pkg::DIV_LAST_STEP) begin
						step_q  <= 4'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					if (step_q == lgvta_pkg::MUL_LAST_STEP) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					state_q <= ST_IDLE;
					if (found_q) begin
						latch_q <= latch_next;
						count_q <= count_next;
					end else begin
						latch_q <= 1'b0;
						count_q <= 8'd0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					found_q   <= frame.target_found;
					width_q   <= frame.image_width;
					rem_q     <= numer_mag;
					quot_q    <= 15'd0;
					acc_q     <= '0;
					err_neg_q <= numer[13];
					if (frame.image_width == 13'd0) begin
						aerr_q    <= 16'd0;
						err_neg_q <= 1'b0;
					end else if (numer[13]) begin
						aerr_q <= lgvta_pkg::ERR_SAT_NEG_MAG;
					end else begin
						aerr_q <= lgvta_pkg::ERR_SAT_POS;
					end
				end
			end
			ST_DIV: begin
				quot_q <= quot_next;
				rem_q  <= alu_res.carry ? alu_res.sum[12:0] : alu_a[12:0];
				if (step_q == lgvta_pkg::DIV_LAST_STEP) begin
					aerr_q <= {1'b0, quot_next};
				end
			end
			ST_MUL: begin
				acc_q <= alu_res.sum;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_POST);

endmodule

// ----- sv/lidar_gated_visual_target_approach_top.sv -----
// ----------------------------------------------------------------------------
// lidar_gated_visual_target_approach_top: lidar gated target approach
// Front distance tracking from lidar samples and drive commands from camera
// detections, with a configuration write port.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the item channel (item_valid, item_stall, item) and
// results leave on the result channel (result_valid, result_stall, result);
// a transaction completes at a rising edge with valid high and stall low.
// A scan sample yields nothing. A last sample or an empty scan yields a front
// distance report through the pending slot and the output register. A camera
// frame yields one drive command. The sequencer runs 15 quotient steps, then
// 13 multiplier steps, on the single shared adder; a saturated error skips the
// division, and no target or a zero image width skips both.
// While a frame is being worked on, or a result waits for the output
// register, item_stall is high. A stalled result holds in the output register
// and one further result may wait behind it, after which the item channel
// stalls. Reset clears the running minimum, the front distance, the stop
// latch and the close frame count, and restores the register defaults.
// Configuration writes take effect at the next edge and belong to idle time.
// ----------------------------------------------------------------------------
module lidar_gated_visual_target_approach_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  lgvta_pkg::in_item_t  item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output lgvta_pkg::out_item_t result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);

	lgvta_pkg::cfg_t      cfg_q;
	lgvta_pkg::front_t    front;
	lgvta_pkg::front_t    front_next;
	lgvta_pkg::out_item_t pend_q;
	logic                 pend_valid_q;
	lgvta_pkg::out_item_t out_q;
	logic                 out_valid_q;
	lgvta_pkg::out_item_t report;
	lgvta_pkg::out_item_t drive_result;

	logic accept;
	logic sample_en;
	logic close_en;
	logic frame_en;
	logic drive_busy;
	logic drive_done;
	logic out_load;

	// Configuration registers; writes outside idle time are not guarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lgvta_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				lgvta_pkg::CFG_SECTOR_CENTER:     cfg_q.sector_center     <= cfg_data;
				lgvta_pkg::CFG_SECTOR_HALF_WIDTH: cfg_q.sector_half_width <= cfg_data[14:0];
				lgvta_pkg::CFG_STOP_THRESHOLD:    cfg_q.stop_threshold    <= cfg_data;
				lgvta_pkg::CFG_RESUME_THRESHOLD:  cfg_q.resume_threshold  <= cfg_data;
				lgvta_pkg::CFG_CONFIRM_FRAMES:    cfg_q.confirm_frames    <= cfg_data[7:0];
				lgvta_pkg::CFG_YAW_GAIN:          cfg_q.yaw_gain          <= cfg_data[12:0];
				lgvta_pkg::CFG_CENTER_TOLERANCE:  cfg_q.center_tolerance  <= cfg_data[14:0];
				lgvta_pkg::CFG_FORWARD_SPEED:     cfg_q.forward_speed     <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	// The item channel is held off while a frame is in the sequencer or a
	// finished result has not yet reached the output register.
	assign item_stall = drive_busy || pend_valid_q;
	assign accept     = item_valid && !item_stall;
	assign sample_en  = accept && (item.command == lgvta_pkg::CMD_SAMPLE
		|| item.command == lgvta_pkg::CMD_LAST);
	assign close_en   = accept && (item.command == lgvta_pkg::CMD_LAST
		|| item.command == lgvta_pkg::CMD_EMPTY);
	assign frame_en   = accept && item.command == lgvta_pkg::CMD_FRAME;

	lgvta_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_en  (sample_en),
		.close_en   (close_en),
		.item       (item),
		.cfg        (cfg_q),
		.front      (front),
		.front_next (front_next)
	);

	lgvta_drive u_drive (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (frame_en),
		.frame  (item),
		.cfg    (cfg_q),
		.front  (front),
		.busy   (drive_busy),
		.done   (drive_done),
		.result (drive_result)
	);

	// A report carries the freshly closed front distance and nothing else.
	always_comb begin
		report                 = '0;
		report.result_kind     = lgvta_pkg::RESULT_REPORT;
		report.front_distance  = front_next.front_range;
		report.distance_valid  = front_next.front_valid;
	end

	// The pending slot moves into the output register once that is free or
	// being emptied in the same cycle.
	assign out_load = pend_valid_q && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (close_en || drive_done) begin
				pend_valid_q <= 1'b1;
			end else if (out_load) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (close_en) begin
			pend_q <= report;
		end else if (drive_done) begin
			pend_q <= drive_result;
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// A camera frame always occupies the sequencer in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) frame_en |=> drive_busy)
		else $error("camera frame accepted without starting the sequencer");

	// A report never carries steering fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == lgvta_pkg::RESULT_REPORT
		|-> !result.target_detected && !result.near_target
		&& result.linear_speed == 11'd0 && result.turn_rate == 16'sd0)
		else $error("front distance report with steering fields set");

	// Stopped at the target means no motion at all.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.near_target
		|-> result.linear_speed == 11'd0 && result.turn_rate == 16'sd0)
		else $error("motion commanded while stopped at the target");

	// A finished frame never lands on a result still waiting in the slot.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_done |-> !pend_valid_q)
		else $error("drive result would overwrite a pending result");

endmodule

// ----- verif/lidar_gated_visual_target_approach_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_gated_visual_target_approach_top_tb: self-checking bench of the approach block
// Drives lidar scans and camera frames through the item channel. An internal
// prediction of the front distance and drive law checks every result field.
// ----------------------------------------------------------------------------

// Prediction of the block: sector gating, running minimum, stop latch and
// the proportional steering law, plus the queue of outputs still due.
class approach_model;
	lgvta_pkg::cfg_t      regs;
	logic [15:0]          scan_min;
	logic                 scan_min_ok;
	logic [15:0]          front;
	logic                 front_ok;
	logic                 stop_held;
	logic [7:0]           close_run;
	lgvta_pkg::out_item_t due_outputs[$];
	int                   errors;
	int                   reports_seen;
	int                   drives_seen;

	function new();
		regs         = lgvta_pkg::CFG_RESET;
		scan_min     = 16'hFFFF;
		scan_min_ok  = 1'b0;
		front        = 16'd0;
		front_ok     = 1'b0;
		stop_held    = 1'b0;
		close_run    = 8'd0;
		errors       = 0;
		reports_seen = 0;
		drives_seen  = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
		lgvta_pkg::CFG_SECTOR_CENTER:     regs.sector_center     = val;
		lgvta_pkg::CFG_SECTOR_HALF_WIDTH: regs.sector_half_width = val[14:0];
		lgvta_pkg::CFG_STOP_THRESHOLD:    regs.stop_threshold    = val;
		lgvta_pkg::CFG_RESUME_THRESHOLD:  regs.resume_threshold  = val;
		lgvta_pkg::CFG_CONFIRM_FRAMES:    regs.confirm_frames    = val[7:0];
		lgvta_pkg::CFG_YAW_GAIN:          regs.yaw_gain          = val[12:0];
		lgvta_pkg::CFG_CENTER_TOLERANCE:  regs.center_tolerance  = val[14:0];
		default:                          regs.forward_speed     = val[10:0];
		endcase
	endfunction

	function void fold_sample(lgvta_pkg::in_item_t it);
		logic [15:0] d;
		logic [16:0] mag;
		d   = it.sample_angle - regs.sector_center;
		mag = d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d};
		if (mag > {2'b00, regs.sector_half_width})
			return;
		if (!it.range_finite)
			return;
		if (it.sample_range <= it.scan_range_min || it.sample_range >= it.scan_range_max)
			return;
		if (!scan_min_ok || it.sample_range < scan_min) begin
			scan_min    = it.sample_range;
			scan_min_ok = 1'b1;
		end
	endfunction

	function void note_item(lgvta_pkg::in_item_t it);
		lgvta_pkg::out_item_t o;
		longint               w;
		longint               cx;
		longint               err;
		longint               aerr;
		longint               wz;
		logic                 near;
		o = '0;
		case (it.command)
		lgvta_pkg::CMD_SAMPLE: begin
			fold_sample(it);
			return;
		end
		lgvta_pkg::CMD_LAST, lgvta_pkg::CMD_EMPTY: begin
			if (it.command == lgvta_pkg::CMD_LAST)
				fold_sample(it);
			if (it.command == lgvta_pkg::CMD_LAST && scan_min_ok) begin
				front    = scan_min;
				front_ok = 1'b1;
			end else begin
				front    = 16'd0;
				front_ok = 1'b0;
			end
			scan_min         = 16'hFFFF;
			scan_min_ok      = 1'b0;
			o.result_kind    = lgvta_pkg::RESULT_REPORT;
			o.front_distance = front;
			o.distance_valid = front_ok;
		end
		default: begin
			o.result_kind     = lgvta_pkg::RESULT_DRIVE;
			o.front_distance  = front;
			o.distance_valid  = front_ok;
			o.target_detected = it.target_found;
			if (!it.target_found) begin
				stop_held   = 1'b0;
				close_run   = 8'd0;
				o.turn_rate = lgvta_pkg::SEARCH_TURN_RATE;
			end else begin
				w   = it.image_width;
				cx  = it.target_x;
				err = 0;
				if (w != 0)
					err = ((w - 2 * cx) * 32768) / w;
				if (err > 32767)
					err = 32767;
				if (err < -32768)
					err = -32768;
				aerr = (err < 0) ? -err : err;
				wz = -(longint'(regs.yaw_gain) * err) / 32768;
				if (wz > 32767)
					wz = 32767;
				if (wz < -32768)
					wz = -32768;
				if (((wz < 0) ? -wz : wz) < longint'(lgvta_pkg::MIN_TURN_RATE)
						&& aerr > longint'(regs.center_tolerance))
					wz = (wz > 0) ? longint'(lgvta_pkg::MIN_TURN_RATE)
						: -longint'(lgvta_pkg::MIN_TURN_RATE);
				if (front_ok && front <= regs.stop_threshold) begin
					if (close_run < lgvta_pkg::COUNT_MAX)
						close_run++;
				end else begin
					close_run = 8'd0;
				end
				near = 1'b0;
				if (close_run >= regs.confirm_frames) begin
					stop_held = 1'b1;
					near      = 1'b1;
				end else if (stop_held) begin
					if (front_ok && front > regs.resume_threshold) begin
						stop_held = 1'b0;
						close_run = 8'd0;
					end else begin
						near = 1'b1;
					end
				end
				if (near) begin
					o.near_target = 1'b1;
				end else begin
					o.linear_speed = (aerr < longint'(lgvta_pkg::CENTERED_LIMIT_Q15))
						? regs.forward_speed : 11'd0;
					o.turn_rate = wz[15:0];
				end
			end
		end
		endcase
		due_outputs.push_back(o);
	endfunction

	function void compare_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	function void check_result(lgvta_pkg::out_item_t got);
		lgvta_pkg::out_item_t want;
		if (due_outputs.size() == 0) begin
			$display("%0t: result with nothing due, expected none actual %h", $time, got);
			errors++;
			return;
		end
		want = due_outputs.pop_front();
		if (want.result_kind == lgvta_pkg::RESULT_REPORT)
			reports_seen++;
		else
			drives_seen++;
		compare_field("result_kind", want.result_kind, got.result_kind);
		compare_field("front_distance", want.front_distance, got.front_distance);
		compare_field("distance_valid", want.distance_valid, got.distance_valid);
		compare_field("target_detected", want.target_detected, got.target_detected);
		compare_field("near_target", want.near_target, got.near_target);
		compare_field("linear_speed", want.linear_speed, got.linear_speed);
		compare_field("turn_rate", want.turn_rate, got.turn_rate);
	endfunction
endclass

module lidar_gated_visual_target_approach_top_tb;
	import lgvta_pkg::*;

	// The slowest plausible run has about 1800 items, with full divide and
	// multiply frames, stalls and gaps. The limit leaves several times its length
	// as margin.
	localparam int CYCLE_LIMIT   = 1000000;
	// Long enough for a frame with a full divide and multiply to finish, so
	// anything still in flight comes out.
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_ITEMS  = 250;
	localparam int BURST_FRAMES  = 262;

	localparam cfg_t CFG_MAX = '{
		sector_center:     16'hFFFF,
		sector_half_width: 15'h7FFF,
		stop_threshold:    16'hFFFF,
		resume_threshold:  16'hFFFF,
		confirm_frames:    8'hFF,
		yaw_gain:          13'd8000,
		center_tolerance:  15'h7FFF,
		forward_speed:     11'd2000
	};

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	in_item_t    item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	out_item_t   result;
	logic        cfg_we       = 1'b0;
	logic [2:0]  cfg_index    = 3'd0;
	logic [15:0] cfg_data     = 16'd0;

	approach_model model;

	// Idling knobs, in percent per cycle, set by the main sequence.
	int   idle_pct    = 0;
	int   stall_pct   = 0;
	// A request for a long hold-off of the result channel; the receiver
	// process counts the cycles itself.
	logic hold_req    = 1'b0;
	int   hold_left   = 0;
	int   cycle_count = 0;
	int   items_sent  = 0;

	lidar_gated_visual_target_approach_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, model.due_outputs.size());
			$display("lidar_gated_visual_target_approach_top: mismatch");
			$finish;
		end
	end

	// Receiver. Every result transaction is checked at the edge that
	// completes it; values read here are those from before the edge. The
	// stall for the next cycle is then chosen, either from the long hold-off
	// or at random.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			model.check_result(result);
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic in_item_t rand_item();
		in_item_t it;
		it.command        = cmd_t'($urandom_range(3));
		it.sample_angle   = 16'($urandom);
		it.sample_range   = 16'($urandom);
		it.range_finite   = 1'($urandom);
		it.scan_range_min = 16'($urandom);
		it.scan_range_max = 16'($urandom);
		it.target_found   = 1'($urandom);
		it.target_x       = 12'($urandom);
		it.image_width    = 13'($urandom);
		return it;
	endfunction

	// Fields that the command does not use are left random on purpose.
	function automatic in_item_t mk_sample(cmd_t c, int ang, int rng, bit fin, int rmin,
			int rmax);
		in_item_t it;
		it                = rand_item();
		it.command        = c;
		it.sample_angle   = 16'(ang);
		it.sample_range   = 16'(rng);
		it.range_finite   = fin;
		it.scan_range_min = 16'(rmin);
		it.scan_range_max = 16'(rmax);
		return it;
	endfunction

	function automatic in_item_t mk_frame(bit found, int cx, int w);
		in_item_t it;
		it              = rand_item();
		it.command      = CMD_FRAME;
		it.target_found = found;
		it.target_x     = 12'(cx);
		it.image_width  = 13'(w);
		return it;
	endfunction

	// Mostly typical values, with the register's own extremes now and then.
	function automatic int pick(int lo, int hi, int typ_lo, int typ_hi);
		case ($urandom_range(4))
		0:       return lo;
		1:       return hi;
		default: return $urandom_range(typ_hi, typ_lo);
		endcase
	endfunction

	function automatic cfg_t rand_cfg();
		cfg_t c;
		c.sector_center     = 16'(pick(0, 65535, 0, 65535));
		c.sector_half_width = 15'(pick(0, 32767, 50, 6000));
		c.stop_threshold    = 16'(pick(0, 65535, 100, 2000));
		if ($urandom_range(3) == 0)
			c.resume_threshold = 16'(pick(0, 65535, 100, 2500));
		else
			c.resume_threshold = 16'(int'(c.stop_threshold) + int'($urandom_range(300)));
		c.confirm_frames    = 8'(pick(0, 255, 0, 5));
		c.yaw_gain          = 13'(pick(0, 8000, 0, 8000));
		c.center_tolerance  = 15'(pick(0, 32767, 0, 8000));
		c.forward_speed     = 11'(pick(0, 2000, 0, 2000));
		return c;
	endfunction

	// Offers one item and holds it until the block takes it. Valid is
	// driven only from here and from drain, once per time step.
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		model.note_item(it);
		items_sent++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		model.write_reg(idx, val);
	endtask

	task automatic apply_config(cfg_t c);
		write_reg(CFG_SECTOR_CENTER, c.sector_center);
		write_reg(CFG_SECTOR_HALF_WIDTH, c.sector_half_width);
		write_reg(CFG_STOP_THRESHOLD, c.stop_threshold);
		write_reg(CFG_RESUME_THRESHOLD, c.resume_threshold);
		write_reg(CFG_CONFIRM_FRAMES, c.confirm_frames);
		write_reg(CFG_YAW_GAIN, c.yaw_gain);
		write_reg(CFG_CENTER_TOLERANCE, c.center_tolerance);
		write_reg(CFG_FORWARD_SPEED, c.forward_speed);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every due result has arrived, then lets a settling stretch
	// pass, so the next phase starts idle.
	task automatic drain();
		item_valid <= 1'b0;
		while (model.due_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(int mode);
		case (mode)
		0: begin idle_pct = 0;  stall_pct = 0;  end
		1: begin idle_pct = 73; stall_pct = 0;  end
		2: begin idle_pct = 0;  stall_pct = 73; end
		default: begin idle_pct = 27; stall_pct = 27; end
		endcase
	endtask

	// One well-formed scan: a few samples spread around the front sector,
	// with ranges clustered around the thresholds and the scan bounds, closed
	// by a last sample.
	task automatic send_scan();
		int c;
		int hw;
		int span;
		int n;
		int i;
		int rmin;
		int rmax;
		int rng;
		int ang;
		c    = model.regs.sector_center;
		hw   = model.regs.sector_half_width;
		span = hw + hw / 8 + 8;
		rmin = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(400));
		rmax = ($urandom_range(3) == 0) ? 65535 : int'($urandom_range(65535, 1000));
		n    = $urandom_range(6, 1);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(6) == 0)
				ang = $urandom_range(65535);
			else
				ang = c + int'($urandom_range(2 * span)) - span;
			case ($urandom_range(3))
			0: rng = int'(model.regs.stop_threshold) + int'($urandom_range(60)) - 30;
			1: rng = int'(model.regs.resume_threshold) + int'($urandom_range(60)) - 30;
			2: rng = (($urandom_range(1) == 0) ? rmin : rmax) + int'($urandom_range(2)) - 1;
			default: rng = $urandom_range(65535);
			endcase
			send_item(mk_sample((i == n - 1) ? CMD_LAST : CMD_SAMPLE, ang, rng,
				$urandom_range(9) != 0, rmin, rmax));
		end
	endtask

	// A few camera frames: common widths mostly, odd and oversized widths
	// and a zero width now and then, the target often near the centre.
	task automatic send_frames();
		int n;
		int i;
		int w;
		int cx;
		n = $urandom_range(3, 1);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(19))
			0:          w = 0;
			1:          w = $urandom_range(8191, 4097);
			2, 3, 4, 5: w = $urandom_range(4096, 1);
			default:    w = 320 << $urandom_range(2);
			endcase
			case ($urandom_range(3))
			0:       cx = $urandom_range(4095);
			1:       cx = w / 2 + int'($urandom_range(w / 8 + 2)) - (w / 16 + 1);
			default: cx = (w > 0) ? int'($urandom_range(w - 1)) : 0;
			endcase
			send_item(mk_frame($urandom_range(6) != 0, cx, w));
		end
	endtask

	// Mostly scans followed by frames; the rest is random noise, which also
	// gives frames without a scan and samples out of order, and empty scans.
	task automatic run_traffic(int count);
		int       start;
		in_item_t it;
		start = items_sent;
		while (items_sent - start < count) begin
			case ($urandom_range(19))
			0, 1: send_item(rand_item());
			2: begin
				it         = rand_item();
				it.command = CMD_EMPTY;
				send_item(it);
			end
			default: begin
				send_scan();
				send_frames();
			end
			endcase
		end
	endtask

	initial begin
		cfg_t next_cfg;
		int   p;
		int   k;
		model = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the default registers written explicitly and
		// no idling on either side.
		apply_config(CFG_RESET);
		set_idle(0);
		// An empty scan reports an invalid distance; a frame without a
		// target turns at the search rate.
		send_item(mk_sample(CMD_EMPTY, 0, 0, 1'b0, 0, 0));
		send_item(mk_frame(1'b0, 0, 640));
		// Steering with no valid distance: the minimum turn in both
		// directions, a saturated error each way, zero width and a small
		// error below the tolerance.
		send_item(mk_frame(1'b1, 290, 640));
		send_item(mk_frame(1'b1, 350, 640));
		send_item(mk_frame(1'b1, 0, 640));
		send_item(mk_frame(1'b1, 4095, 1));
		send_item(mk_frame(1'b1, 100, 0));
		send_item(mk_frame(1'b1, 310, 640));
		// Sector edge inside, one step outside, the opposite bearing, a
		// non-finite range and ranges equal to either scan bound.
		send_item(mk_sample(CMD_SAMPLE, 32768, 300, 1'b1, 100, 10000));
		send_item(mk_sample(CMD_SAMPLE, 32768 + 1820, 200, 1'b1, 100, 10000));
		send_item(mk_sample(CMD_SAMPLE, 32768 - 1821, 50, 1'b1, 100, 10000));
		send_item(mk_sample(CMD_SAMPLE, 0, 20, 1'b1, 0, 65535));
		send_item(mk_sample(CMD_SAMPLE, 32768, 10, 1'b0, 0, 10000));
		send_item(mk_sample(CMD_SAMPLE, 32768, 100, 1'b1, 100, 10000));
		send_item(mk_sample(CMD_SAMPLE, 32768, 10000, 1'b1, 100, 10000));
		send_item(mk_sample(CMD_LAST, 32768, 0, 1'b1, 0, 65535));
		// Two close frames in a row latch the stop.
		send_item(mk_frame(1'b1, 320, 640));
		send_item(mk_frame(1'b1, 320, 640));
		// A scan with nothing valid keeps the stop held, since the latch
		// only releases on a valid distance above the resume threshold.
		send_item(mk_sample(CMD_LAST, 32768, 300, 1'b0, 0, 65535));
		send_item(mk_frame(1'b1, 320, 640));
		send_item(mk_sample(CMD_LAST, 32768, 600, 1'b1, 0, 65535));
		send_item(mk_frame(1'b1, 320, 640));
		// Stop again, then lose the target, which clears the latch.
		send_item(mk_sample(CMD_LAST, 32768, 400, 1'b1, 0, 65535));
		send_item(mk_frame(1'b1, 320, 640));
		send_item(mk_frame(1'b1, 320, 640));
		send_item(mk_frame(1'b0, 320, 640));
		drain();

		// Random phases. Each one starts idle with a fresh register setting;
		// the second and third use the upper and lower extremes of every
		// register, and the idling pattern rotates through all four modes.
		for (p = 0; p < 6; p++) begin
			case (p)
			1:       next_cfg = CFG_MAX;
			2:       next_cfg = '0;
			default: next_cfg = rand_cfg();
			endcase
			apply_config(next_cfg);
			set_idle(p % 4);
			// In the first phase the receiver holds off for a long stretch
			// while items keep coming, so the output buffering fills and the
			// item channel has to stall.
			if (p == 0)
				hold_req = 1'b1;
			if (p == 1) begin
				// With confirm_frames at its maximum, a long run of close
				// frames drives the close count into saturation.
				send_item(mk_sample(CMD_LAST, 16'hFFFF, 1000, 1'b1, 0, 65535));
				for (k = 0; k < BURST_FRAMES; k++)
					send_item(mk_frame(1'b1, $urandom_range(639), 640));
				run_traffic(40);
			end else begin
				run_traffic(RANDOM_ITEMS);
			end
			drain();
		end

		// A last quiet stretch with the receiver always ready, so a stray
		// result would surface before the verdict.
		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items over seven phases and checked %0d distance reports, %0d drive commands.",
			items_sent, model.reports_seen, model.drives_seen);
		$display("Register extremes, stop latch release, close count saturation and long output hold-off were exercised.");
		if (model.errors == 0 && model.due_outputs.size() == 0) begin
			$display("lidar_gated_visual_target_approach_top: match");
		end else begin
			$display("%0d mismatches, %0d results never arrived.", model.errors,
				model.due_outputs.size());
			$display("lidar_gated_visual_target_approach_top: mismatch");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/lgvta_pkg.sv
sv/lgvta_alu.sv
sv/lgvta_scan.sv
sv/lgvta_drive.sv
sv/lidar_gated_visual_target_approach_top.sv
verif/lidar_gated_visual_target_approach_top_tb.sv
